### src/mdc_pkg.sv
// ----------------------------------------------------------------------------
// mdc_pkg: shared types and constants for the matrix double centering block
// Field widths, operation codes, register indexes and the saturation helper.
// ----------------------------------------------------------------------------
`default_nettype none

package mdc_pkg;

  localparam int MAX_DIM_DEF = 1024;

  localparam int KIND_W   = 2;
  localparam int SAMPLE_W = 16;
  localparam int IDX_W    = 10;
  localparam int CFG_W    = 11;
  localparam int CFG_IDX_W = 1;
  localparam int RES_W    = 36;
  localparam int SUM_W    = 48;
  localparam int ACC_W    = 64;
  localparam int TERM_W   = 32;
  localparam int CELL_W   = 2 * CFG_W;
  localparam int DVS_W    = 24;

  localparam logic [CFG_W-1:0] CFG_COUNT_RST = 11'd1024;

  // input item kinds
  localparam logic [KIND_W-1:0] KIND_LOAD   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_EMIT   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REPORT = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_COL = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_ROW = 1'b1;

  localparam logic signed [ACC_W-1:0] RES_MAX = 64'sd34359738367;
  localparam logic signed [ACC_W-1:0] RES_MIN = -64'sd34359738368;
  localparam logic signed [ACC_W-1:0] GM_LIM  = 64'sd1125899906842624;

  // command handed from the front to the back
  typedef struct packed {
    logic [KIND_W-1:0]        op;
    logic signed [TERM_W-1:0] term;
    logic [IDX_W-1:0]         row_idx;
    logic [IDX_W-1:0]         col_idx;
    logic                     row_ok;
    logic                     col_ok;
  } mdc_cmd_t;

  // effective dimensions
  typedef struct packed {
    logic [CFG_W-1:0]  col_eff;
    logic [CFG_W-1:0]  row_eff;
    logic [CELL_W-1:0] cells;
  } mdc_dims_t;

  // divider request
  typedef struct packed {
    logic                    start;
    logic signed [ACC_W-1:0] dividend;
    logic [DVS_W-1:0]        divisor;
  } mdc_div_req_t;

  function automatic logic signed [RES_W-1:0] sat36(input logic signed [ACC_W-1:0] v);
    logic signed [RES_W-1:0] r;
    if (v > RES_MAX) begin
      r = RES_MAX[RES_W-1:0];
    end else if (v < RES_MIN) begin
      r = RES_MIN[RES_W-1:0];
    end else begin
      r = v[RES_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### src/mdc_if.sv
// ----------------------------------------------------------------------------
// mdc_if: stream channels of the matrix double centering block
// Input item channel and result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface mdc_in_if;
  logic                                valid;
  logic                                ready;
  logic [mdc_pkg::KIND_W-1:0]          kind;
  logic signed [mdc_pkg::SAMPLE_W-1:0] sample;
  logic [mdc_pkg::IDX_W-1:0]           col_index;
  logic [mdc_pkg::IDX_W-1:0]           row_index;

  modport source (output valid, kind, sample, col_index, row_index, input ready);
  modport sink (input valid, kind, sample, col_index, row_index, output ready);
endinterface

interface mdc_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [mdc_pkg::RES_W-1:0] result_value;
  logic                             is_mean;

  modport source (output valid, result_value, is_mean, input ready);
  modport sink (input valid, result_value, is_mean, output ready);
endinterface

`default_nettype wire

### src/mdc_ram.sv
// ----------------------------------------------------------------------------
// mdc_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mdc_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### src/mdc_front.sv
// ----------------------------------------------------------------------------
// mdc_front: accept and classify input transactions
// Forms the term, drops dead items and queues commands for the back.
// ----------------------------------------------------------------------------
`default_nettype none

module mdc_front #(
  parameter int MAX_DIM = mdc_pkg::MAX_DIM_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  mdc_in_if.sink         in_ch,
  input  wire logic      clearing,
  output logic           q_valid,
  output mdc_pkg::mdc_cmd_t q_head,
  input  wire logic      q_pop
);

  localparam int QDEPTH = 2;

  logic                              accept;
  logic                              keep;
  logic                              push;
  logic signed [mdc_pkg::TERM_W-1:0] sq;
  logic [mdc_pkg::TERM_W-1:0]        half;
  mdc_pkg::mdc_cmd_t                 cmd;
  mdc_pkg::mdc_cmd_t                 entries_r [QDEPTH];
  logic                              wr_ptr_r;
  logic                              rd_ptr_r;
  logic [1:0]                        cnt_r;

  assign in_ch.ready = !clearing && (cnt_r != 2'(QDEPTH));
  assign accept      = in_ch.valid && in_ch.ready;

  // term = -(s*s)/2, rounded toward zero
  assign sq   = in_ch.sample * in_ch.sample;
  assign half = {1'b0, sq[mdc_pkg::TERM_W-1:1]};

  always_comb begin
    cmd.op      = in_ch.kind;
    cmd.term    = -$signed(half);
    cmd.row_idx = in_ch.row_index;
    cmd.col_idx = in_ch.col_index;
    cmd.row_ok  = 32'(in_ch.row_index) < 32'(MAX_DIM);
    cmd.col_ok  = 32'(in_ch.col_index) < 32'(MAX_DIM);
  end

  // drop unused kinds and loads outside the storage
  always_comb begin
    unique case (in_ch.kind)
      mdc_pkg::KIND_LOAD:   keep = cmd.row_ok && cmd.col_ok;
      mdc_pkg::KIND_EMIT:   keep = 1'b1;
      mdc_pkg::KIND_REPORT: keep = 1'b1;
      default:              keep = 1'b0;
    endcase
  end

  assign push = accept && keep;

  // command queue
  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (q_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      cnt_r <= cnt_r + 2'(push) - 2'(q_pop);
    end
  end

  assign q_valid = (cnt_r != 2'd0);
  assign q_head  = entries_r[rd_ptr_r];

endmodule

`default_nettype wire

### src/mdc_div.sv
// ----------------------------------------------------------------------------
// mdc_div: shared serial divider
// Signed 64-bit dividend by positive divisor, one quotient bit per cycle,
// quotient truncated toward zero.
// ----------------------------------------------------------------------------
`default_nettype none

module mdc_div (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire mdc_pkg::mdc_div_req_t           req,
  output logic                                 done,
  output logic signed [mdc_pkg::ACC_W-1:0]     quotient
);

  localparam int DW   = mdc_pkg::ACC_W;
  localparam int VW   = mdc_pkg::DVS_W;
  localparam int CW   = $clog2(DW);
  localparam logic [CW-1:0] LAST = CW'(DW - 1);

  logic [DW-1:0] dvd_r;
  logic [VW-1:0] rem_r;
  logic [VW-1:0] dvs_r;
  logic          neg_r;
  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [VW:0]   rem_sh;
  logic          fits;
  logic [VW:0]   rem_sub;

  // restoring step
  assign rem_sh  = {rem_r, dvd_r[DW-1]};
  assign fits    = rem_sh >= {1'b0, dvs_r};
  assign rem_sub = rem_sh - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd_r <= req.dividend[DW-1] ? DW'(-req.dividend) : req.dividend;
      rem_r <= '0;
      dvs_r <= req.divisor;
      neg_r <= req.dividend[DW-1];
    end else if (busy_r) begin
      dvd_r <= {dvd_r[DW-2:0], fits};
      rem_r <= fits ? rem_sub[VW-1:0] : rem_sh[VW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = neg_r ? -$signed(dvd_r) : $signed(dvd_r);

endmodule

`default_nettype wire

### src/mdc_back.sv
// ----------------------------------------------------------------------------
// mdc_back: command execution
// Sum memories, grand and centered totals, divisions and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module mdc_back #(
  parameter int MAX_DIM = mdc_pkg::MAX_DIM_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              q_valid,
  input  wire mdc_pkg::mdc_cmd_t q_head,
  output logic                   q_pop,
  output logic                   clearing,
  input  wire mdc_pkg::mdc_dims_t dims,
  mdc_out_if.source              out_ch
);

  localparam int AW = $clog2(MAX_DIM);
  localparam int XW = AW + mdc_pkg::IDX_W;
  localparam int SW = mdc_pkg::SUM_W;
  localparam int GW = mdc_pkg::ACC_W;
  localparam logic [AW-1:0] ADDR_LAST = AW'(MAX_DIM - 1);

  localparam logic [2:0] S_CLEAR    = 3'd0;
  localparam logic [2:0] S_IDLE     = 3'd1;
  localparam logic [2:0] S_READ     = 3'd2;
  localparam logic [2:0] S_DIV_ROW  = 3'd3;
  localparam logic [2:0] S_DIV_COL  = 3'd4;
  localparam logic [2:0] S_DIV_GM   = 3'd5;
  localparam logic [2:0] S_DIV_MEAN = 3'd6;
  localparam logic [2:0] S_OUT      = 3'd7;

  logic [2:0]               state_r;
  logic [2:0]               state_nxt;
  mdc_pkg::mdc_cmd_t        cmd_r;
  logic [AW-1:0]            clr_addr_r;
  logic signed [GW-1:0]     grand_r;
  logic signed [GW-1:0]     centered_r;
  logic signed [GW-1:0]     cs_r;
  logic signed [GW-1:0]     acc_r;
  logic signed [GW-1:0]     gm_r;
  logic signed [mdc_pkg::RES_W-1:0] mean_r;
  logic                     out_valid_r;
  logic signed [mdc_pkg::RES_W-1:0] res_r;
  logic                     is_mean_r;

  logic [XW-1:0]            row_ext_q;
  logic [XW-1:0]            col_ext_q;
  logic [XW-1:0]            row_ext_c;
  logic [XW-1:0]            col_ext_c;
  logic [AW-1:0]            waddr_row;
  logic [AW-1:0]            waddr_col;
  logic                     we;
  logic [SW-1:0]            wdata_row;
  logic [SW-1:0]            wdata_col;
  logic [SW-1:0]            rdata_row;
  logic [SW-1:0]            rdata_col;
  logic signed [SW-1:0]     term48;
  logic signed [GW-1:0]     term64;
  logic signed [GW-1:0]     rs64;
  logic signed [GW-1:0]     cs64;
  logic signed [GW-1:0]     emit_sum;
  logic signed [mdc_pkg::RES_W-1:0] emit_val;
  logic                     out_free;
  logic                     is_load;
  mdc_pkg::mdc_div_req_t    div_req;
  logic                     div_done;
  logic signed [GW-1:0]     div_q;

  assign clearing = (state_r == S_CLEAR);
  assign out_free = !out_valid_r || out_ch.ready;
  assign q_pop    = (state_r == S_IDLE) && q_valid;
  assign is_load  = (cmd_r.op == mdc_pkg::KIND_LOAD);

  // memory addresses
  assign row_ext_q = XW'(q_head.row_idx);
  assign col_ext_q = XW'(q_head.col_idx);
  assign row_ext_c = XW'(cmd_r.row_idx);
  assign col_ext_c = XW'(cmd_r.col_idx);

  assign term48 = SW'(cmd_r.term);
  assign term64 = GW'(cmd_r.term);
  assign rs64   = cmd_r.row_ok ? GW'($signed(rdata_row)) : '0;
  assign cs64   = cmd_r.col_ok ? GW'($signed(rdata_col)) : '0;

  // write back a load, or zero during the clearing sweep
  always_comb begin
    we        = clearing || ((state_r == S_READ) && is_load);
    waddr_row = clearing ? clr_addr_r : row_ext_c[AW-1:0];
    waddr_col = clearing ? clr_addr_r : col_ext_c[AW-1:0];
    wdata_row = clearing ? '0 : rdata_row + term48;
    wdata_col = clearing ? '0 : rdata_col + term48;
  end

  mdc_ram #(.WIDTH(SW), .DEPTH(MAX_DIM)) u_row_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr_row),
    .wdata (wdata_row),
    .raddr (row_ext_q[AW-1:0]),
    .rdata (rdata_row)
  );

  mdc_ram #(.WIDTH(SW), .DEPTH(MAX_DIM)) u_col_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr_col),
    .wdata (wdata_col),
    .raddr (col_ext_q[AW-1:0]),
    .rdata (rdata_col)
  );

  // divider requests
  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = rs64;
    div_req.divisor  = mdc_pkg::DVS_W'(dims.col_eff);
    unique case (state_r)
      S_READ: begin
        div_req.start = !is_load;
      end
      S_DIV_ROW: begin
        div_req.start    = div_done;
        div_req.dividend = cs_r;
        div_req.divisor  = mdc_pkg::DVS_W'(dims.row_eff);
      end
      S_DIV_COL: begin
        div_req.start    = div_done;
        div_req.dividend = grand_r;
        div_req.divisor  = mdc_pkg::DVS_W'(dims.cells);
      end
      S_IDLE: begin
        div_req.start    = q_valid && (q_head.op == mdc_pkg::KIND_REPORT);
        div_req.dividend = centered_r;
        div_req.divisor  = mdc_pkg::DVS_W'(dims.cells);
      end
      default: begin
      end
    endcase
  end

  mdc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .done     (div_done),
    .quotient (div_q)
  );

  assign emit_sum = acc_r + gm_r;
  assign emit_val = mdc_pkg::sat36(emit_sum);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR:    if (clr_addr_r == ADDR_LAST) state_nxt = S_IDLE;
      S_IDLE: begin
        if (q_valid) begin
          state_nxt = (q_head.op == mdc_pkg::KIND_REPORT) ? S_DIV_MEAN : S_READ;
        end
      end
      S_READ:     state_nxt = is_load ? S_IDLE : S_DIV_ROW;
      S_DIV_ROW:  if (div_done) state_nxt = S_DIV_COL;
      S_DIV_COL:  if (div_done) state_nxt = S_DIV_GM;
      S_DIV_GM:   if (div_done) state_nxt = S_OUT;
      S_DIV_MEAN: if (div_done) state_nxt = S_OUT;
      S_OUT: begin
        if (out_free) begin
          state_nxt = is_load ? S_IDLE
                    : ((cmd_r.op == mdc_pkg::KIND_REPORT) ? S_CLEAR : S_IDLE);
        end
      end
      default:    state_nxt = S_CLEAR;
    endcase
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd_r <= q_head;
    end
    if ((state_r == S_READ) && !is_load) begin
      cs_r <= cs64;
    end
    if ((state_r == S_DIV_ROW) && div_done) begin
      acc_r <= term64 - div_q;
    end
    if ((state_r == S_DIV_COL) && div_done) begin
      acc_r <= acc_r - div_q;
    end
    if ((state_r == S_DIV_GM) && div_done) begin
      if (div_q > mdc_pkg::GM_LIM) begin
        gm_r <= mdc_pkg::GM_LIM;
      end else if (div_q < -mdc_pkg::GM_LIM) begin
        gm_r <= -mdc_pkg::GM_LIM;
      end else begin
        gm_r <= div_q;
      end
    end
    // hold the mean aside while an earlier result may still wait on out_ch
    if ((state_r == S_DIV_MEAN) && div_done) begin
      mean_r <= mdc_pkg::sat36(div_q);
    end
    if ((state_r == S_OUT) && out_free) begin
      res_r     <= (cmd_r.op == mdc_pkg::KIND_REPORT) ? mean_r : emit_val;
      is_mean_r <= (cmd_r.op == mdc_pkg::KIND_REPORT);
    end
  end

  // control, totals and result handshake
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      grand_r     <= '0;
      centered_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (clearing) begin
        clr_addr_r <= clr_addr_r + 1'b1;
      end else begin
        clr_addr_r <= '0;
      end
      if ((state_r == S_READ) && is_load) begin
        grand_r <= grand_r + term64;
      end
      if (out_ch.valid && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if ((state_r == S_OUT) && out_free) begin
        out_valid_r <= 1'b1;
        if (cmd_r.op == mdc_pkg::KIND_REPORT) begin
          grand_r    <= '0;
          centered_r <= '0;
        end else begin
          centered_r <= centered_r + GW'(emit_val);
        end
      end
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.result_value = res_r;
  assign out_ch.is_mean      = is_mean_r;

endmodule

`default_nettype wire

### src/matrix_double_centering_top.sv
// ----------------------------------------------------------------------------
// matrix_double_centering_top: double centering of a squared matrix
// Two streamed passes: load builds row, column and grand sums of -s*s/2;
// emit returns the centered element; report returns the mean and clears.
// ----------------------------------------------------------------------------
//  port group   | direction | carries
//  in_ch        | sink      | kind, sample, col_index, row_index
//  out_ch       | source    | result_value, is_mean
//  cfg_*        | write     | column_count (index 0), row_count (index 1)
//
// A load reads and writes back its sums in the back; an emit runs three
// passes of the shared one-bit-per-cycle divider, and a report runs one
// pass plus a sweep over all MAX_DIM addresses that zeroes the row and
// column sum memories; the same sweep follows reset, and no transaction
// is taken on in_ch while it runs. A two-entry command queue parts the
// input from the back, and the result register holds while out_ch stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module matrix_double_centering_top #(
  parameter int MAX_DIM = mdc_pkg::MAX_DIM_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  mdc_in_if.sink                               in_ch,
  mdc_out_if.source                            out_ch,
  input  wire logic                            cfg_we,
  input  wire logic [mdc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [mdc_pkg::CFG_W-1:0]       cfg_data
);

  localparam int CW = mdc_pkg::CFG_W;

  logic [CW-1:0]              col_count_r;
  logic [CW-1:0]              row_count_r;
  logic [mdc_pkg::CELL_W-1:0] cells_r;
  mdc_pkg::mdc_dims_t         dims;
  logic                       q_valid;
  logic                       q_pop;
  logic                       clearing;
  mdc_pkg::mdc_cmd_t          q_head;

  function automatic logic [CW-1:0] eff_count(input logic [CW-1:0] c);
    logic [CW-1:0] r;
    if (c == '0) begin
      r = CW'(1);
    end else if (32'(c) > 32'(MAX_DIM)) begin
      r = CW'(MAX_DIM);
    end else begin
      r = c;
    end
    return r;
  endfunction

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_count_r <= mdc_pkg::CFG_COUNT_RST;
      row_count_r <= mdc_pkg::CFG_COUNT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mdc_pkg::CFG_IDX_COL: col_count_r <= cfg_data;
        mdc_pkg::CFG_IDX_ROW: row_count_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // register the element count
  always_ff @(posedge clk) begin
    cells_r <= eff_count(col_count_r) * eff_count(row_count_r);
  end

  assign dims.col_eff = eff_count(col_count_r);
  assign dims.row_eff = eff_count(row_count_r);
  assign dims.cells   = cells_r;

  mdc_front #(.MAX_DIM(MAX_DIM)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .clearing (clearing),
    .q_valid  (q_valid),
    .q_head   (q_head),
    .q_pop    (q_pop)
  );

  mdc_back #(.MAX_DIM(MAX_DIM)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .clearing (clearing),
    .dims     (dims),
    .out_ch   (out_ch)
  );

endmodule

`default_nettype wire

### test/mdc_checker.sv
// ----------------------------------------------------------------------------
// mdc_checker: result predictor and scoreboard for matrix double centering
// Watches the input, result and configuration ports, keeps its own copy of
// the row, column, grand and centered sums, and checks every result in order.
// ----------------------------------------------------------------------------
module mdc_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  mdc_in_if                             in_ch,
  mdc_out_if                            out_ch,
  input  logic                          cfg_we,
  input  logic [mdc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mdc_pkg::CFG_W-1:0]     cfg_data,
  output int                            fail_count,
  output int                            pending
);
  import mdc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DIM = MAX_DIM_DEF;

  typedef struct {
    logic signed [RES_W-1:0] value;
    logic                    is_mean;
  } centered_result_t;

  logic [CFG_W-1:0]        col_count;
  logic [CFG_W-1:0]        row_count;
  logic [SUM_W-1:0]        row_total [DIM];
  logic [SUM_W-1:0]        col_total [DIM];
  logic [ACC_W-1:0]        grand_total;
  logic [ACC_W-1:0]        centered_total;
  centered_result_t        expected_results [$];

  // zero counts act as one, oversize counts as the array depth
  function automatic longint clip_count(logic [CFG_W-1:0] c);
    if (c == 0) return 1;
    if (c > DIM) return DIM;
    return longint'(c);
  endfunction

  function automatic longint clamp_result(longint v);
    if (v > 64'sd34359738367) return 64'sd34359738367;
    if (v < -64'sd34359738368) return -64'sd34359738368;
    return v;
  endfunction

  // update sums for one accepted transaction; push a result if one is due
  task automatic predict_centering(logic [KIND_W-1:0] kind, logic signed [SAMPLE_W-1:0] s,
                                   logic [IDX_W-1:0] col, logic [IDX_W-1:0] row);
    longint sv, term, cc, rc, rs, cs, gm, v;
    centered_result_t r;
    logic signed [SUM_W-1:0] rs48, cs48;
    sv = longint'(s);
    term = -((sv * sv) >>> 1);
    cc = clip_count(col_count);
    rc = clip_count(row_count);
    case (kind)
      KIND_LOAD: begin
        row_total[row] = row_total[row] + SUM_W'(term);
        col_total[col] = col_total[col] + SUM_W'(term);
        grand_total = grand_total + ACC_W'(term);
      end
      KIND_EMIT: begin
        rs48 = row_total[row];
        cs48 = col_total[col];
        rs = longint'(rs48);
        cs = longint'(cs48);
        gm = longint'($signed(grand_total)) / (cc * rc);
        if (gm > 64'sd1125899906842624) gm = 64'sd1125899906842624;
        if (gm < -64'sd1125899906842624) gm = -64'sd1125899906842624;
        v = clamp_result(term - rs / cc - cs / rc + gm);
        centered_total = centered_total + ACC_W'(v);
        r.value = v[RES_W-1:0];
        r.is_mean = 1'b0;
        expected_results.push_back(r);
      end
      KIND_REPORT: begin
        v = clamp_result(longint'($signed(centered_total)) / (cc * rc));
        r.value = v[RES_W-1:0];
        r.is_mean = 1'b1;
        expected_results.push_back(r);
        foreach (row_total[i]) row_total[i] = '0;
        foreach (col_total[i]) col_total[i] = '0;
        grand_total = '0;
        centered_total = '0;
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    centered_result_t exp_r;
    if (!rst_n) begin
      col_count = CFG_COUNT_RST;
      row_count = CFG_COUNT_RST;
      foreach (row_total[i]) row_total[i] = '0;
      foreach (col_total[i]) col_total[i] = '0;
      grand_total = '0;
      centered_total = '0;
      expected_results.delete();
      fail_count <= 0;
    end else begin
      // compare first: a result never belongs to a transaction of this edge
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result: result_value %0d is_mean %0d",
                 out_ch.result_value, out_ch.is_mean);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = expected_results.pop_front();
          if (out_ch.result_value !== exp_r.value) begin
            $error("result_value expected %0d actual %0d", exp_r.value, out_ch.result_value);
            fail_count <= fail_count + 1;
          end
          if (out_ch.is_mean !== exp_r.is_mean) begin
            $error("is_mean expected %0d actual %0d", exp_r.is_mean, out_ch.is_mean);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_ch.valid && in_ch.ready)
        predict_centering(in_ch.kind, in_ch.sample, in_ch.col_index, in_ch.row_index);
      if (cfg_we) begin
        if (cfg_index == CFG_IDX_COL) col_count = cfg_data;
        else if (cfg_index == CFG_IDX_ROW) row_count = cfg_data;
      end
    end
    pending <= expected_results.size();
  end

endmodule

### test/testbench.sv
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for matrix_double_centering_top
// Streams small matrices through both passes and a report under several
// dimension settings, with random sender and receiver stalls, plus noise.
// ----------------------------------------------------------------------------
module testbench;
  import mdc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE_CYCLES = 1300;
  localparam int STALL_LIMIT   = 20000;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_IDX_COL;
  logic [CFG_W-1:0]     cfg_data = '0;
  int                   fail_count;
  int                   pending;
  int                   idle_phase = 0;
  int                   items_sent = 0;
  int                   quiet_cycles = 0;

  mdc_in_if  in_ch ();
  mdc_out_if out_ch ();

  matrix_double_centering_top u_top (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  mdc_checker u_checker (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  always #5 clk = ~clk;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.kind = KIND_LOAD;
    in_ch.sample = '0;
    in_ch.col_index = '0;
    in_ch.row_index = '0;
    out_ch.ready = 1'b0;
  end

  // receiver stalls: heavy, then light, then none
  always @(posedge clk) begin
    int pct;
    pct = (idle_phase == 0) ? 64 : (idle_phase == 1) ? 37 : 0;
    out_ch.ready <= ($urandom_range(99) >= pct);
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL matrix_double_centering_top");
      $finish;
    end
  end

  task automatic send_item(logic [KIND_W-1:0] kind, logic signed [SAMPLE_W-1:0] s,
                           logic [IDX_W-1:0] col, logic [IDX_W-1:0] row);
    int pct;
    pct = (idle_phase == 0) ? 37 : (idle_phase == 1) ? 64 : 0;
    while ($urandom_range(99) < pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind <= kind;
    in_ch.sample <= s;
    in_ch.col_index <= col;
    in_ch.row_index <= row;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
    idle_phase = (items_sent < 270) ? 0 : (items_sent < 540) ? 1 : 2;
  endtask

  // drain results and let the clearing sweep finish before touching registers
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(9))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return '0;
      default: return SAMPLE_W'($urandom_range(65535));
    endcase
  endfunction

  // both passes over a cols x rows block, random noise mixed in, then report
  task automatic run_matrix(int cols, int rows);
    logic signed [SAMPLE_W-1:0] vals [$];
    int k;
    for (int c = 0; c < cols; c++)
      for (int r = 0; r < rows; r++) begin
        vals.push_back(pick_sample());
        send_item(KIND_LOAD, vals[$], IDX_W'(c), IDX_W'(r));
      end
    k = 0;
    for (int c = 0; c < cols; c++)
      for (int r = 0; r < rows; r++) begin
        if ($urandom_range(9) == 0)
          send_item(KIND_LOAD + KIND_W'($urandom_range(3)), pick_sample(),
                    IDX_W'($urandom_range(1023)), IDX_W'($urandom_range(1023)));
        send_item(KIND_EMIT, vals[k], IDX_W'(c), IDX_W'(r));
        k++;
      end
    send_item(KIND_REPORT, pick_sample(), '0, '0);
  endtask

  initial begin
    int cols, rows;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes at default dimensions, unused kind, unloaded emits
    send_item(KIND_LOAD, 16'sh8000, 10'd1023, 10'd0);
    send_item(KIND_LOAD, 16'sh7FFF, 10'd0, 10'd1023);
    send_item(KIND_LOAD, 16'sh0001, 10'd682, 10'd341);
    send_item(KIND_LOAD, 16'shFFFF, 10'd341, 10'd682);
    send_item(KIND_LOAD + 2'd3, 16'sh5555, 10'd1023, 10'd1023);
    send_item(KIND_EMIT, 16'sh8000, 10'd1023, 10'd0);
    send_item(KIND_EMIT, 16'sh7FFF, 10'd0, 10'd1023);
    send_item(KIND_EMIT, 16'sh0001, 10'd682, 10'd341);
    send_item(KIND_EMIT, 16'sh0000, 10'd5, 10'd7);
    send_item(KIND_REPORT, 16'sh0000, 10'd0, 10'd0);
    settle();

    // zero counts act as one; oversize counts clip
    write_reg(CFG_IDX_COL, 11'd0);
    write_reg(CFG_IDX_ROW, 11'd0);
    run_matrix(1, 1);
    settle();
    write_reg(CFG_IDX_COL, 11'd2047);
    write_reg(CFG_IDX_ROW, 11'd1);
    run_matrix(3, 2);
    settle();
    write_reg(CFG_IDX_COL, 11'd1);
    write_reg(CFG_IDX_ROW, 11'd2047);
    run_matrix(2, 3);
    settle();

    // random dimensions; indices past the count are kept as given
    while (items_sent < 800) begin
      cols = $urandom_range(1, 6);
      rows = $urandom_range(1, 6);
      write_reg(CFG_IDX_COL, ($urandom_range(4) == 0) ? CFG_W'($urandom_range(2047))
                                                      : CFG_W'(cols));
      write_reg(CFG_IDX_ROW, ($urandom_range(4) == 0) ? CFG_W'($urandom_range(2047))
                                                      : CFG_W'(rows));
      run_matrix(cols, rows);
      settle();
    end

    if (fail_count == 0) begin
      $display("PASS matrix_double_centering_top");
    end else begin
      $display("FAIL matrix_double_centering_top");
    end
    $finish;
  end

endmodule

### sim.f
src/mdc_pkg.sv
src/mdc_if.sv
src/mdc_ram.sv
src/mdc_front.sv
src/mdc_div.sv
src/mdc_back.sv
src/matrix_double_centering_top.sv
test/mdc_checker.sv
test/testbench.sv
